### hw/rtl/tbf_pkg.sv
// Shared constants, codes and field widths for the tensor broadcast fetch block.
`default_nettype none

package tbf_pkg;

    // Field widths of the stream payloads.
    localparam int INDEX_W  = 32;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int CMD_W    = 1;

    // Configuration register format.
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_INDEX_W = 3;
    localparam int RANK_W      = 4;
    localparam int SLOT_COUNT  = 8;
    localparam int SLOT_BITS   = 3;
    localparam int SLOT_W      = 16;

    // Running shape products saturate here; anything at or above 2^32 compares alike.
    localparam int TOTAL_W = 33;
    localparam logic [TOTAL_W-1:0] TOTAL_CAP = 33'h1_0000_0000;

    // Parameter defaults.
    localparam int STORE_DEPTH_DEF   = 4096;
    localparam int MAX_RANK_DEF      = 8;
    localparam int ELEMENT_WIDTH_DEF = 32;
    localparam int DIM_WIDTH_DEF     = 16;

    // Register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_OUTPUT_RANK      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_INPUT_RANK       = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_OUTPUT_DIMS_LOW  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_OUTPUT_DIMS_HIGH = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_INPUT_DIMS_LOW   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_INPUT_DIMS_HIGH  = 3'd5;

    // Reset values of the registers: rank one, every dimension one.
    localparam logic [RANK_W-1:0]     RANK_RESET = 4'd1;
    localparam logic [CFG_DATA_W-1:0] DIMS_RESET = 64'h0001_0001_0001_0001;

    // Commands and status codes.
    localparam logic [CMD_W-1:0] CMD_LOAD  = 1'b0;
    localparam logic [CMD_W-1:0] CMD_FETCH = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_SHAPE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

endpackage

`default_nettype wire

### hw/rtl/tensor_broadcast_fetch.sv
// A load answers in the cycle after its beat is taken; a fetch checks each of the R output
// dimensions, then divides once per output dimension before it reads the store.
// One item at a time; the next beat is taken in the cycle after the result leaves,
// and the shared 32-step divider, run once per output dimension, sets the fetch time.
// Shape and range errors answer before the divider runs. Reset clears the control state
// and the shape registers (ranks 1, all dimensions 1); the element store is not cleared.
`default_nettype none

module tensor_broadcast_fetch #(
    parameter int STORE_DEPTH   = tbf_pkg::STORE_DEPTH_DEF,
    parameter int MAX_RANK      = tbf_pkg::MAX_RANK_DEF,
    parameter int ELEMENT_WIDTH = tbf_pkg::ELEMENT_WIDTH_DEF,
    parameter int DIM_WIDTH     = tbf_pkg::DIM_WIDTH_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // Configuration write port.
    input  wire logic                               i_cfg_we,
    input  wire logic [tbf_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  wire logic [tbf_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // Item stream in.
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // tdata: element_index [31:0], load_value [63:32]
    input  wire logic [tbf_pkg::INDEX_W+tbf_pkg::VALUE_W-1:0] s_axis_tdata,
    // tuser: command [0]
    input  wire logic [tbf_pkg::CMD_W-1:0]          s_axis_tuser,
    // Result stream out.
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // tdata: fetch_value [31:0]
    output logic [tbf_pkg::VALUE_W-1:0]             m_axis_tdata,
    // tuser: status [1:0]
    output logic [tbf_pkg::STATUS_W-1:0]            m_axis_tuser
);

    localparam int AW    = $clog2(STORE_DEPTH);
    localparam int CNT_W = $clog2(STORE_DEPTH + 1);
    localparam int IW    = tbf_pkg::INDEX_W;
    localparam int TW    = tbf_pkg::TOTAL_W;
    localparam int SB    = tbf_pkg::SLOT_BITS;
    localparam int RW    = tbf_pkg::RANK_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_INDEX,
        S_DIV_START,
        S_DIV_WAIT,
        S_READ,
        S_GRAB,
        S_OUT
    } t_state;

    // Shape registers.
    logic [RW-1:0]                   r_orank;
    logic [RW-1:0]                   r_irank;
    logic [tbf_pkg::CFG_DATA_W-1:0]  r_odims_lo;
    logic [tbf_pkg::CFG_DATA_W-1:0]  r_odims_hi;
    logic [tbf_pkg::CFG_DATA_W-1:0]  r_idims_lo;
    logic [tbf_pkg::CFG_DATA_W-1:0]  r_idims_hi;

    // Sequencer and datapath registers.
    t_state                          r_state;
    logic [SB-1:0]                   r_d;
    logic [IW-1:0]                   r_idx;
    logic [IW-1:0]                   r_rest;
    logic [TW-1:0]                   r_total;
    logic [TW-1:0]                   r_in_total;
    logic [CNT_W-1:0]                r_lin;
    logic [CNT_W-1:0]                r_stride;
    logic                            r_out_valid;
    logic [tbf_pkg::VALUE_W-1:0]     r_out_data;
    logic [tbf_pkg::STATUS_W-1:0]    r_out_status;

    // Element store.
    logic [ELEMENT_WIDTH-1:0]        r_store [STORE_DEPTH];
    logic [ELEMENT_WIDTH-1:0]        r_mem_q;

    logic [TW-1:0]                   n_total;
    logic [TW-1:0]                   n_in_total;
    logic [CNT_W-1:0]                n_lin;
    logic [CNT_W-1:0]                n_stride;

    logic                            w_in_accept;
    logic [IW-1:0]                   w_in_index;
    logic [tbf_pkg::VALUE_W-1:0]     w_in_value;
    logic                            w_load_ok;
    logic [RW-1:0]                   w_gap;
    logic                            w_padded;
    logic [DIM_WIDTH-1:0]            w_outd;
    logic [DIM_WIDTH-1:0]            w_pind;
    logic [DIM_WIDTH-1:0]            w_coord;
    logic                            w_rank_bad;
    logic                            w_dim_bad;
    logic                            w_last;
    logic [DIM_WIDTH+CNT_W-1:0]      w_cs;
    logic [DIM_WIDTH+CNT_W-1:0]      w_sp;

    logic                            w_div_start;
    logic                            w_div_done;
    logic [IW-1:0]                   w_div_quo;
    logic [DIM_WIDTH-1:0]            w_div_rem;

    // Dimension k from a pair of 64-bit registers, sixteen-bit slots, low bits used.
    function automatic logic [DIM_WIDTH-1:0] slot_of(
        input logic [tbf_pkg::CFG_DATA_W-1:0] lo,
        input logic [tbf_pkg::CFG_DATA_W-1:0] hi,
        input logic [SB-1:0]                  k
    );
        logic [2*tbf_pkg::CFG_DATA_W-1:0] both;
        both = {hi, lo};
        return both[{k, 4'b0000} +: DIM_WIDTH];
    endfunction

    function automatic logic [TW-1:0] capped_mul(
        input logic [TW-1:0]        a,
        input logic [DIM_WIDTH-1:0] b
    );
        logic [TW+DIM_WIDTH-1:0] p;
        p = (TW+DIM_WIDTH)'(a) * (TW+DIM_WIDTH)'(b);
        return (p > (TW+DIM_WIDTH)'(tbf_pkg::TOTAL_CAP)) ? tbf_pkg::TOTAL_CAP : p[TW-1:0];
    endfunction

    assign w_in_accept = s_axis_tvalid && s_axis_tready;
    assign w_in_index  = s_axis_tdata[IW-1:0];
    assign w_in_value  = s_axis_tdata[IW+tbf_pkg::VALUE_W-1:IW];
    assign w_load_ok   = w_in_index < IW'(STORE_DEPTH);

    assign w_rank_bad = (r_orank == '0) || (r_orank > RW'(MAX_RANK)) ||
                        (r_irank == '0) || (r_irank > RW'(MAX_RANK)) ||
                        (r_irank > r_orank);

    // Input shape is left-padded with ones up to the output rank.
    assign w_gap    = r_orank - r_irank;
    assign w_padded = {1'b0, r_d} < w_gap;
    assign w_outd   = slot_of(r_odims_lo, r_odims_hi, r_d);
    assign w_pind   = w_padded ? DIM_WIDTH'(1)
                               : slot_of(r_idims_lo, r_idims_hi, SB'({1'b0, r_d} - w_gap));
    assign w_dim_bad = (w_pind == '0) ||
                       ((w_pind != DIM_WIDTH'(1)) && (w_pind != w_outd));
    assign w_last    = r_d == SB'(r_orank - RW'(1));

    assign n_total    = capped_mul(r_total, w_outd);
    assign n_in_total = capped_mul(r_in_total, w_pind);

    // Broadcast dimensions read coordinate zero.
    assign w_coord  = (w_pind == DIM_WIDTH'(1)) ? '0 : w_div_rem;
    assign w_cs     = (DIM_WIDTH+CNT_W)'(w_coord) * (DIM_WIDTH+CNT_W)'(r_stride);
    assign w_sp     = (DIM_WIDTH+CNT_W)'(w_pind) * (DIM_WIDTH+CNT_W)'(r_stride);
    assign n_lin    = r_lin + CNT_W'(w_cs);
    assign n_stride = CNT_W'(w_sp);

    assign w_div_start = r_state == S_DIV_START;

    tbf_divider #(
        .DIM_WIDTH (DIM_WIDTH)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_div_start),
        .i_dividend  (r_rest),
        .i_divisor   (w_outd),
        .o_done      (w_div_done),
        .o_quotient  (w_div_quo),
        .o_remainder (w_div_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_orank    <= tbf_pkg::RANK_RESET;
            r_irank    <= tbf_pkg::RANK_RESET;
            r_odims_lo <= tbf_pkg::DIMS_RESET;
            r_odims_hi <= tbf_pkg::DIMS_RESET;
            r_idims_lo <= tbf_pkg::DIMS_RESET;
            r_idims_hi <= tbf_pkg::DIMS_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                tbf_pkg::REG_OUTPUT_RANK:      r_orank    <= i_cfg_data[RW-1:0];
                tbf_pkg::REG_INPUT_RANK:       r_irank    <= i_cfg_data[RW-1:0];
                tbf_pkg::REG_OUTPUT_DIMS_LOW:  r_odims_lo <= i_cfg_data;
                tbf_pkg::REG_OUTPUT_DIMS_HIGH: r_odims_hi <= i_cfg_data;
                tbf_pkg::REG_INPUT_DIMS_LOW:   r_idims_lo <= i_cfg_data;
                tbf_pkg::REG_INPUT_DIMS_HIGH:  r_idims_hi <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept && (s_axis_tuser == tbf_pkg::CMD_LOAD) && w_load_ok) begin
            r_store[w_in_index[AW-1:0]] <= ELEMENT_WIDTH'(w_in_value);
        end
        r_mem_q <= r_store[r_lin[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_d         <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_in_accept) begin
                        r_idx        <= w_in_index;
                        r_out_data   <= '0;
                        r_out_status <= tbf_pkg::STATUS_OK;
                        if (s_axis_tuser == tbf_pkg::CMD_LOAD) begin
                            if (!w_load_ok) begin
                                r_out_status <= tbf_pkg::STATUS_RANGE;
                            end
                            r_out_valid <= 1'b1;
                            r_state     <= S_OUT;
                        end else if (w_rank_bad) begin
                            r_out_status <= tbf_pkg::STATUS_SHAPE;
                            r_out_valid  <= 1'b1;
                            r_state      <= S_OUT;
                        end else begin
                            r_d        <= '0;
                            r_total    <= TW'(1);
                            r_in_total <= TW'(1);
                            r_state    <= S_CHECK;
                        end
                    end
                end
                S_CHECK: begin
                    if (w_dim_bad) begin
                        r_out_status <= tbf_pkg::STATUS_SHAPE;
                        r_out_valid  <= 1'b1;
                        r_state      <= S_OUT;
                    end else begin
                        r_total    <= n_total;
                        r_in_total <= n_in_total;
                        r_d        <= r_d + 1'b1;
                        if (w_last) begin
                            r_state <= S_INDEX;
                        end
                    end
                end
                S_INDEX: begin
                    if (r_in_total > TW'(STORE_DEPTH)) begin
                        r_out_status <= tbf_pkg::STATUS_SHAPE;
                        r_out_valid  <= 1'b1;
                        r_state      <= S_OUT;
                    end else if ({1'b0, r_idx} >= r_total) begin
                        r_out_status <= tbf_pkg::STATUS_RANGE;
                        r_out_valid  <= 1'b1;
                        r_state      <= S_OUT;
                    end else begin
                        // Last dimension runs fastest, so peel it off first.
                        r_d      <= SB'(r_orank - RW'(1));
                        r_rest   <= r_idx;
                        r_lin    <= '0;
                        r_stride <= CNT_W'(1);
                        r_state  <= S_DIV_START;
                    end
                end
                S_DIV_START: begin
                    r_state <= S_DIV_WAIT;
                end
                S_DIV_WAIT: begin
                    if (w_div_done) begin
                        r_rest   <= w_div_quo;
                        r_lin    <= n_lin;
                        r_stride <= n_stride;
                        if (r_d == '0) begin
                            r_state <= S_READ;
                        end else begin
                            r_d     <= r_d - 1'b1;
                            r_state <= S_DIV_START;
                        end
                    end
                end
                S_READ: begin
                    r_state <= S_GRAB;
                end
                S_GRAB: begin
                    r_out_data  <= tbf_pkg::VALUE_W'(r_mem_q);
                    r_out_valid <= 1'b1;
                    r_state     <= S_OUT;
                end
                S_OUT: begin
                    if (m_axis_tready) begin
                        r_out_valid <= 1'b0;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_out_valid <= 1'b0;
                    r_state     <= S_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = r_state == S_IDLE;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_status;

    // A result beat is only ever shown while the sequencer waits in its output state.
    a_valid_in_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_state == S_OUT))
        else $error("result valid outside output state");

    // The divider only finishes while the sequencer is waiting for it.
    a_div_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_DIV_WAIT))
        else $error("divider finished while not awaited");

    // A recombined index always lands inside the store.
    a_lin_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> (r_lin < CNT_W'(STORE_DEPTH)))
        else $error("recombined index beyond the store");

    // Error beats carry a zero element.
    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_status != tbf_pkg::STATUS_OK)) |-> (r_out_data == '0))
        else $error("error beat with nonzero data");

    // A load answers in the very next cycle.
    a_load_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_accept && (s_axis_tuser == tbf_pkg::CMD_LOAD)) |=> r_out_valid)
        else $error("load did not answer at once");

endmodule

`default_nettype wire

### hw/rtl/tbf_divider.sv
// Restoring divider: 32-bit dividend by a dimension-wide divisor, one quotient bit per cycle.
`default_nettype none

module tbf_divider #(
    parameter int DIM_WIDTH = tbf_pkg::DIM_WIDTH_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic [tbf_pkg::INDEX_W-1:0]  i_dividend,
    input  wire logic [DIM_WIDTH-1:0]         i_divisor,
    output logic                              o_done,
    output logic [tbf_pkg::INDEX_W-1:0]       o_quotient,
    output logic [DIM_WIDTH-1:0]              o_remainder
);

    localparam int CNT_W = $clog2(tbf_pkg::INDEX_W);

    logic                        r_busy;
    logic                        r_done;
    logic [CNT_W-1:0]            r_cnt;
    logic [tbf_pkg::INDEX_W-1:0] r_quo;
    logic [DIM_WIDTH-1:0]        r_rem;
    logic [DIM_WIDTH-1:0]        r_div;

    logic [DIM_WIDTH:0] w_trial;
    logic [DIM_WIDTH:0] w_diff;
    logic               w_fits;

    // Bring down the next dividend bit and try to subtract the divisor.
    assign w_trial = {r_rem, r_quo[tbf_pkg::INDEX_W-1]};
    assign w_fits  = w_trial >= {1'b0, r_div};
    assign w_diff  = w_trial - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(tbf_pkg::INDEX_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[tbf_pkg::INDEX_W-2:0], w_fits};
            r_rem <= w_fits ? w_diff[DIM_WIDTH-1:0] : w_trial[DIM_WIDTH-1:0];
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

`default_nettype wire
